FILE: hdl/dds_pkg.sv
// Shared types, constants and the sine table generator for the DDS output channel.
// No dependencies; every other file imports this package.
package dds_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int DIGIT_W   = 4;   // serial digit width
  localparam int TICK_W    = 8;
  localparam int FREQ_W    = 32;
  localparam int AMP_W     = 15;
  localparam int LEVEL_W   = 16;
  localparam int SINE_W    = 16;
  localparam int SINE_FRAC = 15;
  localparam int MODE_W    = 2;

  localparam int TICK_DIGITS = (TICK_W + DIGIT_W - 1) / DIGIT_W;
  localparam int TICK_CNT_W  = (TICK_DIGITS > 1) ? $clog2(TICK_DIGITS) : 1;
  localparam int AMP_DIGITS  = (AMP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int AMP_PAD_W   = AMP_DIGITS * DIGIT_W;
  localparam int AMP_CNT_W   = (AMP_DIGITS > 1) ? $clog2(AMP_DIGITS) : 1;
  localparam int PROD_W      = AMP_W + SINE_W;
  localparam int RAW_W       = LEVEL_W + 1;

  localparam int LEVEL_MAX = 20480;
  localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(LEVEL_MAX);
  localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_W'(LEVEL_MAX);

  // APB register file
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_DC     = 3'd1,
    REG_FREQ   = 3'd2,
    REG_AMP    = 3'd3,
    REG_OFFSET = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 2'd0,
    MODE_DC   = 2'd1,
    MODE_SINE = 2'd2
  } mode_t;

  localparam logic [MODE_W-1:0]         MODE_RST   = MODE_OFF;
  localparam logic signed [LEVEL_W-1:0] DC_RST     = '0;
  localparam logic [FREQ_W-1:0]         FREQ_RST   = 32'd4294967;
  localparam logic [AMP_W-1:0]          AMP_RST    = 15'd2048;
  localparam logic signed [LEVEL_W-1:0] OFFSET_RST = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROM,
    ST_LOAD,
    ST_MULT,
    ST_HOLD
  } dds_state_t;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  // sin(pi/2 * k / 2^q_bits) scaled to 32767, Taylor series in Q30 up to x^13
  function automatic longint quarter_sine(longint k, int q_bits);
    longint x;
    longint t;
    longint s;
    x = (PI_Q30 * k) >>> (q_bits + 1);
    t = x;
    s = x;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 6;   s += t;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 20;  s += t;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 42;  s += t;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 72;  s += t;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 110; s += t;
    t = t * x / Q30_ONE; t = t * x / Q30_ONE; t = -t / 156; s += t;
    if (s < 0) s = 0;
    if (s > Q30_ONE) s = Q30_ONE;
    return (s * 32767 + Q30_ONE / 2) / Q30_ONE;
  endfunction

  // Full-wave entry i of a 2^tb entry table, built from quarter-wave symmetry
  function automatic logic signed [SINE_W-1:0] sine_entry(int i, int tb);
    int     q_bits;
    longint q;
    longint quad;
    longint k;
    longint v;
    q_bits = tb - 2;
    q      = longint'(1) << q_bits;
    quad   = longint'(i) >> q_bits;
    k      = longint'(i) & (q - 1);
    case (quad)
      0:       v = quarter_sine(k, q_bits);
      1:       v = quarter_sine(q - k, q_bits);
      2:       v = -quarter_sine(k, q_bits);
      default: v = -quarter_sine(q - k, q_bits);
    endcase
    return SINE_W'(v);
  endfunction

endpackage

FILE: hdl/dds_if.sv
// Valid/ready channel interfaces for tick items and output levels.
// Depends on dds_pkg for field widths.
interface dds_tick_if;
  import dds_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] elapsed_ticks;
  modport source (output valid, output elapsed_ticks, input ready);
  modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface dds_level_if;
  import dds_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;
  logic                      clipped;
  modport source (output valid, output level, output clipped, input ready);
  modport sink (input valid, input level, input clipped, output ready);
endinterface

FILE: hdl/dds_waveform_output_channel.sv
// Top level of one DDS waveform output channel: APB registers, sequencer, output register.
// Depends on dds_pkg, dds_if, dds_phase, dds_sine_rom, dds_scale.
//
//   channel   dir   handshake          payload
//   tick      in    valid/ready        elapsed_ticks[7:0]
//   result    out   valid/ready        level[15:0] signed, clipped
//   apb       in    psel/penable       paddr[4:0], pwdata/prdata[31:0], pready tied high
//
// For each item the sequencer runs, in order: 2 digit steps of the phase
// multiply-accumulate and its done flag, the table read, the load, 4 digit
// steps of the amplitude multiply, offset and saturation and its done flag,
// the move of the result into the output register and the return to idle.
// tick.ready is high only while the sequencer is idle. A result waits in the
// output register while the next tick is worked on; the sequencer holds before
// its last step if that register is still full.
// Reset (synchronous, active high) clears the phase accumulator, the registers
// to their defaults and the sequencer; there is no clearing pass.
module dds_waveform_output_channel import dds_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dds_tick_if.sink              tick,
  dds_level_if.source           result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TB = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [MODE_W-1:0]         mode;
  logic signed [LEVEL_W-1:0] dc_level;
  logic [FREQ_W-1:0]         freq_step;
  logic [AMP_W-1:0]          amplitude;
  logic signed [LEVEL_W-1:0] offset_level;

  logic     cfg_wr;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_RST;
      dc_level     <= DC_RST;
      freq_step    <= FREQ_RST;
      amplitude    <= AMP_RST;
      offset_level <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:   mode         <= pwdata[MODE_W-1:0];
        REG_DC:     dc_level     <= pwdata[LEVEL_W-1:0];
        REG_FREQ:   freq_step    <= pwdata[FREQ_W-1:0];
        REG_AMP:    amplitude    <= pwdata[AMP_W-1:0];
        REG_OFFSET: offset_level <= pwdata[LEVEL_W-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = APB_DATA_W'(mode);
      REG_DC:     prdata = APB_DATA_W'(dc_level);
      REG_FREQ:   prdata = APB_DATA_W'(freq_step);
      REG_AMP:    prdata = APB_DATA_W'(amplitude);
      REG_OFFSET: prdata = APB_DATA_W'(offset_level);
      default:    prdata = '0;
    endcase
  end

  // sequencer
  dds_state_t state;
  dds_state_t state_next;

  logic                      phase_start;
  logic                      phase_done;
  logic [PHASE_BITS-1:0]     phase;
  logic signed [SINE_W-1:0]  sine;
  logic                      scale_start;
  logic                      scale_done;
  logic signed [LEVEL_W-1:0] scale_level;
  logic                      scale_clipped;
  logic                      out_free;
  logic                      out_load;
  logic                      tick_ready;

  assign out_free = ~result.valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (tick.valid) state_next = ST_PHASE;
      ST_PHASE: if (phase_done) state_next = ST_ROM;
      ST_ROM:   state_next = ST_LOAD;   // table read in flight
      ST_LOAD:  state_next = ST_MULT;
      ST_MULT:  if (scale_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tick_ready  = (state == ST_IDLE);
    phase_start = (state == ST_IDLE) && tick.valid;
    scale_start = (state == ST_LOAD);
    out_load    = (state == ST_HOLD) && out_free;
  end

  assign tick.ready = tick_ready;

  dds_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .start     (phase_start),
    .freq_step (freq_step),
    .ticks     (tick.elapsed_ticks),
    .done      (phase_done),
    .phase     (phase)
  );

  // table index is the top phase bits
  dds_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (phase[PHASE_BITS-1 -: TB]),
    .data (sine)
  );

  dds_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .start        (scale_start),
    .amplitude    (amplitude),
    .sine         (sine),
    .mode         (mode),
    .dc_level     (dc_level),
    .offset_level (offset_level),
    .done         (scale_done),
    .level        (scale_level),
    .clipped      (scale_clipped)
  );

  // output register
  logic                      out_valid;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      out_clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level   <= scale_level;
      out_clipped <= scale_clipped;
    end
  end

  assign result.valid   = out_valid;
  assign result.level   = out_level;
  assign result.clipped = out_clipped;

endmodule

FILE: hdl/dds_phase.sv
// Phase accumulator with a digit-serial freq_step * ticks multiply-accumulate.
// Depends on dds_pkg.
module dds_phase import dds_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FREQ_W-1:0]     freq_step,
  input  logic [TICK_W-1:0]     ticks,
  output logic                  done,
  output logic [PHASE_BITS-1:0] phase
);

  localparam int PART_W = PHASE_BITS + DIGIT_W;

  logic [PHASE_BITS-1:0] addend;
  logic [TICK_W-1:0]     tick_sr;
  logic [TICK_CNT_W-1:0] cnt;
  logic                  busy;
  logic [PART_W-1:0]     partial;

  // one ticks digit times the shifted step
  assign partial = PART_W'(addend) * PART_W'(tick_sr[DIGIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        phase <= phase + partial[PHASE_BITS-1:0];
        cnt   <= cnt + 1'b1;
        if (cnt == TICK_CNT_W'(TICK_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addend  <= PHASE_BITS'(freq_step);
      tick_sr <= ticks;
    end else if (busy) begin
      addend  <= addend << DIGIT_W;
      tick_sr <= tick_sr >> DIGIT_W;
    end
  end

endmodule

FILE: hdl/dds_sine_rom.sv
// Read-only sine table, Q1.15, filled at elaboration; registered read.
// Depends on dds_pkg (sine_entry).
module dds_sine_rom import dds_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   addr,
  output logic signed [SINE_W-1:0]         data
);

  localparam int TB = $clog2(TABLE_DEPTH);

  typedef logic signed [SINE_W-1:0] rom_t [TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = sine_entry(i, TB);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

FILE: hdl/dds_scale.sv
// Digit-serial amplitude * sine multiply, offset add, mode select and saturation.
// Depends on dds_pkg.
module dds_scale import dds_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [AMP_W-1:0]          amplitude,
  input  logic signed [SINE_W-1:0]  sine,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [LEVEL_W-1:0] dc_level,
  input  logic signed [LEVEL_W-1:0] offset_level,
  output logic                      done,
  output logic signed [LEVEL_W-1:0] level,
  output logic                      clipped
);

  localparam int STEP_W = PROD_W + DIGIT_W + 1;

  logic signed [PROD_W-1:0]  acc;
  logic signed [PROD_W-1:0]  mcand;
  logic [AMP_PAD_W-1:0]      amp_sr;
  logic [AMP_CNT_W-1:0]      cnt;
  logic                      busy;
  logic                      fin;
  logic signed [STEP_W-1:0]  step;
  logic signed [LEVEL_W-1:0] scaled;
  logic signed [RAW_W-1:0]   raw;
  logic signed [RAW_W-1:0]   raw_sel;
  logic signed [LEVEL_W-1:0] level_next;
  logic                      clipped_next;

  assign step = mcand * $signed({1'b0, amp_sr[DIGIT_W-1:0]});

  // arithmetic shift floors, matching rounding toward minus infinity
  assign scaled = acc[PROD_W-1:SINE_FRAC];
  assign raw    = {offset_level[LEVEL_W-1], offset_level} + {scaled[LEVEL_W-1], scaled};

  always_comb begin
    case (mode)
      MODE_DC:   raw_sel = {dc_level[LEVEL_W-1], dc_level};
      MODE_SINE: raw_sel = raw;
      default:   raw_sel = '0;
    endcase
    if (raw_sel > RAW_MAX) begin
      level_next   = LEVEL_W'(RAW_MAX);
      clipped_next = 1'b1;
    end else if (raw_sel < RAW_MIN) begin
      level_next   = LEVEL_W'(RAW_MIN);
      clipped_next = 1'b1;
    end else begin
      level_next   = raw_sel[LEVEL_W-1:0];
      clipped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == AMP_CNT_W'(AMP_DIGITS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PROD_W'(sine);
      amp_sr <= AMP_PAD_W'(amplitude);
    end else if (busy) begin
      acc    <= acc + step[PROD_W-1:0];
      mcand  <= mcand <<< DIGIT_W;
      amp_sr <= amp_sr >> DIGIT_W;
    end
    if (fin) begin
      level   <= level_next;
      clipped <= clipped_next;
    end
  end

endmodule
